// ===== src/sris_pkg.sv =====
package sris_pkg;

  localparam int unsigned NUM_SHIFT_REGS = 4;
  localparam int unsigned HISTORY_BITS   = 8;
  localparam int unsigned NUM_INPUTS     = NUM_SHIFT_REGS * 8;
  localparam int unsigned ADDR_W         = $clog2(NUM_INPUTS);
  localparam int unsigned POS_W          = $clog2(NUM_INPUTS + 1);
  localparam int unsigned ENTRY_W        = HISTORY_BITS + 8;

  localparam int unsigned CFG_IDX_W      = 1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_COUNT = 1'b0;
  localparam logic [7:0] MAX_COUNT_RESET = 8'd8;

  typedef enum logic [1:0] {
    OP_LATCH = 2'd0,
    OP_SHIFT = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  typedef enum logic {
    ST_IDLE,
    ST_MODIFY
  } state_e;

endpackage

// ===== src/sris_ram.sv =====
module sris_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/shift_register_input_scanner.sv =====
// latch items and items that touch no entry (ignored shift, bad read index, unused code) stay in
// idle; in-range shift and read items take a ram read, then modify and write back in ST_MODIFY.
// busy is high in the modify state, so one entry is in flight at a time.
// a read's result is registered after its modify state; result_valid_o pulses for one cycle.
// reset clears the per-entry valid flags (invalid entries read as zero history and count),
// sets max_count to 8 and parks the scan position at the chain end; no clearing pass is needed.
module shift_register_input_scanner
  import sris_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  operation_i,
  input  logic        data_level_i,
  input  logic [7:0]  read_index_i,
  output logic        result_valid_o,
  output logic [7:0]  history_o,
  output logic [7:0]  sample_count_o,
  output logic        has_new_o,
  output logic        index_error_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  state_e state_q, state_d;

  logic [7:0]            max_count_q;
  logic [POS_W-1:0]      pos_q;
  logic [NUM_INPUTS-1:0] valid_q;
  logic                  is_read_q;
  logic                  active_q;
  logic [ADDR_W-1:0]     addr_q;

  logic                  accept;
  logic                  shift_hit;
  logic                  read_hit;
  logic                  read_miss;
  logic [ADDR_W-1:0]     slot;
  logic [ADDR_W-1:0]     raddr;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic                  cfg_write;

  logic [ENTRY_W-1:0]      rdata;
  logic [HISTORY_BITS-1:0] hist_rd;
  logic [7:0]              cnt_rd;
  logic [HISTORY_BITS:0]   hist_shifted;
  logic [HISTORY_BITS-1:0] hist_new;
  logic [8:0]              cnt_inc;
  logic [7:0]              cnt_new;
  logic [ENTRY_W-1:0]      wdata;
  logic                    we;
  logic [HISTORY_BITS+7:0] hist_ext;

  assign accept    = start && !busy;
  assign slot      = pos_q[ADDR_W-1:0] ^ ADDR_W'(7);
  assign shift_hit = (operation_i == OP_SHIFT) && (pos_q < POS_W'(NUM_INPUTS));
  assign read_hit  = (operation_i == OP_READ) && (read_index_i < 8'(NUM_INPUTS));
  assign read_miss = (operation_i == OP_READ) && !(read_index_i < 8'(NUM_INPUTS));
  assign raddr     = read_hit ? read_index_i[ADDR_W-1:0] : slot;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && (shift_hit || read_hit)) begin
          state_d = ST_MODIFY;
        end
      end
      ST_MODIFY: state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    busy = 1'b0;
    we   = 1'b0;
    case (state_q)
      ST_IDLE:   busy = 1'b0;
      ST_MODIFY: begin
        busy = 1'b1;
        we   = 1'b1;
      end
      default:   busy = 1'b0;
    endcase
  end

  sris_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(NUM_INPUTS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(addr_q),
    .wdata_i(wdata),
    .re_i   (accept),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // never-written entries read as zero
  assign hist_rd      = valid_q[addr_q] ? rdata[ENTRY_W-1:8] : '0;
  assign cnt_rd       = valid_q[addr_q] ? rdata[7:0] : 8'd0;
  assign hist_shifted = {hist_rd, active_q};
  assign hist_new     = is_read_q ? hist_rd : hist_shifted[HISTORY_BITS-1:0];
  assign cnt_inc      = {1'b0, cnt_rd} + 9'd1;

  always_comb begin
    if (is_read_q) begin
      cnt_new = 8'd0;
    end else if (cnt_inc > {1'b0, max_count_q}) begin
      cnt_new = max_count_q;
    end else begin
      cnt_new = cnt_inc[7:0];
    end
  end

  assign wdata    = {hist_new, cnt_new};
  assign hist_ext = {8'd0, hist_rd};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      pos_q          <= POS_W'(NUM_INPUTS);
      valid_q        <= '0;
      max_count_q    <= MAX_COUNT_RESET;
      result_valid_o <= 1'b0;
    end else begin
      state_q        <= state_d;
      result_valid_o <= 1'b0;
      if (cfg_write && (cfg_idx == REG_MAX_COUNT)) begin
        max_count_q <= pwdata[7:0];
      end
      if (accept && (operation_i == OP_LATCH)) begin
        pos_q <= '0;
      end else if (accept && shift_hit) begin
        pos_q <= pos_q + POS_W'(1);
      end
      if (we) begin
        valid_q[addr_q] <= 1'b1;
      end
      if ((we && is_read_q) || (accept && read_miss)) begin
        result_valid_o <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      is_read_q <= read_hit;
      active_q  <= ~data_level_i;
      addr_q    <= raddr;
    end
    if (accept && read_miss) begin
      history_o      <= 8'd0;
      sample_count_o <= 8'd0;
      has_new_o      <= 1'b0;
      index_error_o  <= 1'b1;
    end else if (we && is_read_q) begin
      history_o      <= hist_ext[7:0];
      sample_count_o <= cnt_rd;
      has_new_o      <= (cnt_rd != 8'd0);
      index_error_o  <= 1'b0;
    end
  end

  // configuration port
  assign cfg_idx   = paddr[2 +: CFG_IDX_W];
  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;
  assign prdata    = (cfg_idx == REG_MAX_COUNT) ? {24'd0, max_count_q} : 32'd0;

endmodule
